// File: rtl/core/ptie_pkg.sv
// Shared types, constants and edge-wall code functions for the pattern table evaluator.
// No dependencies.
package ptie_pkg;

    localparam int BOARD_SIZE_DEF  = 15;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int PATTERN_COUNT   = 708588;
    localparam int CODE_W          = 20;
    localparam int POL_W           = 18;
    localparam int SUM_W           = 32;
    // signed board coordinate, covers -5 .. 36
    localparam int COORD_W         = 7;
    // signed cell index while walking a line, covers the largest board plus margin
    localparam int IDX_W           = 12;

    // request kinds
    localparam logic [2:0] KIND_WRITE  = 3'd0;
    localparam logic [2:0] KIND_PLACE  = 3'd1;
    localparam logic [2:0] KIND_REMOVE = 3'd2;
    localparam logic [2:0] KIND_CLEAR  = 3'd3;

    localparam logic [CODE_W-1:0] PW3 [11] = '{
        20'd1, 20'd3, 20'd9, 20'd27, 20'd81, 20'd243,
        20'd729, 20'd2187, 20'd6561, 20'd19683, 20'd59049
    };

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         cell_req;
        logic [1:0]         stone;
        logic [1:0]         head;
        logic [19:0]        pattern_code;
        logic signed [15:0] weight_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [17:0] policy_value;
        logic signed [31:0] win_total;
        logic signed [31:0] loss_total;
        logic signed [31:0] draw_total;
    } t_out_beat;

    // one board memory row: colour, four line codes, policy accumulator
    typedef struct packed {
        logic [1:0]                  color;
        logic [3:0][CODE_W-1:0]      code;
        logic [POL_W-1:0]            policy;
    } t_board_row;

    // code of a cell t places in from the low wall
    function automatic logic [CODE_W-1:0] lo_code(int t);
        case (t)
            1:       return 20'd354294;
            2:       return 20'd354295;
            3:       return 20'd354298;
            4:       return 20'd354307;
            default: return 20'd354334;
        endcase
    endfunction

    // code of a cell t places in from the high wall
    function automatic logic [CODE_W-1:0] hi_code(int t);
        case (t)
            1:       return 20'd177147;
            2:       return 20'd236196;
            3:       return 20'd255879;
            4:       return 20'd262440;
            default: return 20'd264627;
        endcase
    endfunction

    // diagonal cell that sees walls at both ends
    function automatic logic [CODE_W-1:0] corner_code(int a, int b);
        logic [CODE_W-1:0] ca;
        logic [CODE_W-1:0] cb;
        case (a)
            1:       ca = 20'd0;
            2:       ca = 20'd59049;
            3:       ca = 20'd78732;
            4:       ca = 20'd85293;
            default: ca = 20'd87480;
        endcase
        case (b)
            1:       cb = 20'd0;
            2:       cb = 20'd1;
            3:       cb = 20'd4;
            4:       cb = 20'd13;
            default: cb = 20'd40;
        endcase
        return 20'd531441 + ca + cb;
    endfunction

    // straight line wall code at position p on a board of n
    function automatic logic [CODE_W-1:0] edge_code(int p, int n);
        if (p <= 4)
            return lo_code(5 - p);
        if (p >= n - 5)
            return hi_code(p - n + 6);
        return '0;
    endfunction

    // diagonal wall code for coordinates p and q
    function automatic logic [CODE_W-1:0] diag_code(int p, int q, int n);
        logic pl;
        logic ph;
        logic ql;
        logic qh;
        int   tp;
        int   tq;
        pl = (p <= 4);
        ph = (p >= n - 5);
        ql = (q <= 4);
        qh = (q >= n - 5);
        if (pl && qh)
            return corner_code(q - n + 6, 5 - p);
        if (ph && ql)
            return corner_code(p - n + 6, 5 - q);
        if (pl || ql) begin
            tp = pl ? 5 - p : 0;
            tq = ql ? 5 - q : 0;
            return lo_code((tp > tq) ? tp : tq);
        end
        if (ph || qh) begin
            tp = ph ? p - n + 6 : 0;
            tq = qh ? q - n + 6 : 0;
            return hi_code((tp > tq) ? tp : tq);
        end
        return '0;
    endfunction

endpackage

// File: rtl/core/ptie_weight_mem.sv
// Four-head weight store: one lane write port, two registered read ports.
// Depends on ptie_pkg. Codes beyond the table read as zero.
module ptie_weight_mem #(
    parameter int WEIGHT_BITS = ptie_pkg::WEIGHT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [19:0]                 i_waddr,
    input  logic [1:0]                  i_whead,
    input  logic [WEIGHT_BITS-1:0]      i_wdata,
    input  logic [19:0]                 i_raddr_a,
    input  logic [19:0]                 i_raddr_b,
    output logic [3:0][WEIGHT_BITS-1:0] o_rdata_a,
    output logic [3:0][WEIGHT_BITS-1:0] o_rdata_b
);
    import ptie_pkg::*;

    logic [3:0][WEIGHT_BITS-1:0] r_mem [PATTERN_COUNT];
    logic [3:0][WEIGHT_BITS-1:0] r_rd_a;
    logic [3:0][WEIGHT_BITS-1:0] r_rd_b;
    logic                        r_ok_a;
    logic                        r_ok_b;

    // lane write, out-of-table codes dropped
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr < 20'(PATTERN_COUNT))) begin
            r_mem[i_waddr][i_whead] <= i_wdata;
        end
    end

    // two read ports
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
        r_ok_a <= (i_raddr_a < 20'(PATTERN_COUNT));
        r_ok_b <= (i_raddr_b < 20'(PATTERN_COUNT));
    end

    assign o_rdata_a = r_ok_a ? r_rd_a : '0;
    assign o_rdata_b = r_ok_b ? r_rd_b : '0;

endmodule

// File: rtl/core/ptie_board_mem.sv
// Board memory: one row per cell with colour, line codes and policy.
// Depends on ptie_pkg. One write and one registered read per cycle.
module ptie_board_mem #(
    parameter int CELL_COUNT = ptie_pkg::BOARD_SIZE_DEF * ptie_pkg::BOARD_SIZE_DEF,
    localparam int AW = $clog2(CELL_COUNT)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  ptie_pkg::t_board_row i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output ptie_pkg::t_board_row o_rdata
);
    import ptie_pkg::*;

    t_board_row r_mem [CELL_COUNT];
    t_board_row r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd;

endmodule

// File: rtl/core/pattern_table_incremental_evaluator.sv
// Top level: request sequencer around the board memory and the weight store.
// Depends on ptie_pkg, ptie_board_mem, ptie_weight_mem.
//
//  channel | direction | valid      | stall       | beat
//  in      | into      | i_in_valid | o_in_stall  | i_in_beat  (t_in_beat)
//  out     | out of    | o_out_valid| i_out_stall | o_out_beat (t_out_beat)
//
// One request at a time. Write, read and unused kinds: S_RES_RD, S_RES.
// Place/remove: S_DIVY splits the cell index; each line code touched (at
// most 44) passes S_WALK_RD, S_WALK_MOD, S_WALK_WR, an off-board slot only
// S_WALK_RD. Clear: S_CLR_A, S_CLR_B, S_CLR_C per cell, two weight reads per
// cycle. After reset a sweep over all BOARD_SIZE^2 cells writes the wall codes;
// input is stalled meanwhile. A result held by i_out_stall blocks the next one.
module pattern_table_incremental_evaluator #(
    parameter int BOARD_SIZE  = ptie_pkg::BOARD_SIZE_DEF,
    parameter int WEIGHT_BITS = ptie_pkg::WEIGHT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ptie_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ptie_pkg::t_out_beat o_out_beat
);
    import ptie_pkg::*;

    localparam int CELLS = BOARD_SIZE * BOARD_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam int EB    = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DIVY, S_CELL_RD, S_CELL_CHK, S_WALK_RD, S_WALK_MOD,
        S_WALK_WR, S_CLR_A, S_CLR_B, S_CLR_C, S_RES_RD, S_RES
    } t_state;

    t_state                     r_state;
    logic                       r_cell_ok;
    logic [AW-1:0]              r_loc;
    logic [AW-1:0]              r_rem;
    logic signed [COORD_W-1:0]  r_x0;
    logic signed [COORD_W-1:0]  r_y0;
    logic [1:0]                 r_col;
    logic                       r_sub;
    logic [1:0]                 r_d;
    logic [3:0]                 r_j;
    logic signed [COORD_W-1:0]  r_x;
    logic signed [COORD_W-1:0]  r_y;
    logic signed [IDX_W-1:0]    r_k;
    t_board_row                 r_row;
    logic [CODE_W-1:0]          r_nc;
    logic [POL_W-1:0]           r_pacc;
    logic [SUM_W-1:0]           r_win;
    logic [SUM_W-1:0]           r_loss;
    logic [SUM_W-1:0]           r_draw;
    logic                       r_out_valid;
    t_out_beat                  r_out_beat;

    // memory ports
    logic                        w_b_we;
    logic [AW-1:0]               w_b_waddr;
    t_board_row                  w_b_wdata;
    logic [AW-1:0]               w_b_raddr;
    t_board_row                  w_b_rdata;
    logic                        w_w_we;
    logic [WEIGHT_BITS-1:0]      w_w_wdata;
    logic [19:0]                 w_w_raddr_a;
    logic [19:0]                 w_w_raddr_b;
    logic [3:0][WEIGHT_BITS-1:0] w_w_rdata_a;
    logic [3:0][WEIGHT_BITS-1:0] w_w_rdata_b;

    logic                        w_accept;
    logic [3:0][CODE_W-1:0]      w_wall;
    logic [1:0]                  w_sd;
    logic signed [COORD_W-1:0]   w_sx;
    logic signed [COORD_W-1:0]   w_sy;
    logic signed [IDX_W-1:0]     w_sk;
    logic signed [IDX_W-1:0]     w_off;
    logic signed [IDX_W-1:0]     w_soff;
    logic signed [1:0]           w_dx;
    logic signed [1:0]           w_dy;
    logic                        w_on_board;
    logic [CODE_W-1:0]           w_delta;
    logic [CODE_W-1:0]           w_oc;
    logic [CODE_W-1:0]           w_nc;
    logic                        w_walk_last;
    logic                        w_sweep_last;
    logic signed [EB-1:0]        w_wtrunc;

    function automatic logic [SUM_W-1:0] wx(logic [WEIGHT_BITS-1:0] w);
        return SUM_W'(signed'(w));
    endfunction

    function automatic logic signed [1:0] dir_dx(logic [1:0] d);
        return (d == 2'd1) ? 2'sd0 : 2'sd1;
    endfunction

    function automatic logic signed [1:0] dir_dy(logic [1:0] d);
        case (d)
            2'd0:    return 2'sd0;
            2'd3:    return -2'sd1;
            default: return 2'sd1;
        endcase
    endfunction

    function automatic logic signed [IDX_W-1:0] dir_off(logic [1:0] d);
        case (d)
            2'd0:    return IDX_W'(1);
            2'd1:    return IDX_W'(BOARD_SIZE);
            2'd2:    return IDX_W'(BOARD_SIZE + 1);
            default: return IDX_W'(1 - BOARD_SIZE);
        endcase
    endfunction

    ptie_board_mem #(.CELL_COUNT(CELLS)) u_board (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_b_waddr),
        .i_wdata (w_b_wdata),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    ptie_weight_mem #(.WEIGHT_BITS(WEIGHT_BITS)) u_weights (
        .i_clk     (i_clk),
        .i_we      (w_w_we),
        .i_waddr   (i_in_beat.pattern_code),
        .i_whead   (i_in_beat.head),
        .i_wdata   (w_w_wdata),
        .i_raddr_a (w_w_raddr_a),
        .i_raddr_b (w_w_raddr_b),
        .o_rdata_a (w_w_rdata_a),
        .o_rdata_b (w_w_rdata_b)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // weight write: sign-extend from the stored width
    assign w_wtrunc  = i_in_beat.weight_value[EB-1:0];
    assign w_w_wdata = WEIGHT_BITS'(w_wtrunc);
    assign w_w_we    = w_accept && (i_in_beat.kind == KIND_WRITE);

    // wall codes for the sweep position
    always_comb begin
        w_wall[0] = edge_code(int'(r_x), BOARD_SIZE);
        w_wall[1] = edge_code(int'(r_y), BOARD_SIZE);
        w_wall[2] = diag_code(int'(r_x), int'(r_y), BOARD_SIZE);
        w_wall[3] = diag_code(int'(r_x), BOARD_SIZE - 1 - int'(r_y), BOARD_SIZE);
    end

    // line walk: start point of a direction and stepping
    assign w_sd   = (r_state == S_CELL_CHK) ? 2'd0 : r_d + 2'd1;
    assign w_soff = dir_off(w_sd);
    assign w_sx   = COORD_W'(r_x0 + 5 * dir_dx(w_sd));
    assign w_sy   = COORD_W'(r_y0 + 5 * dir_dy(w_sd));
    assign w_sk   = IDX_W'($signed({1'b0, r_loc}) + 5 * w_soff);
    assign w_off  = dir_off(r_d);
    assign w_dx   = dir_dx(r_d);
    assign w_dy   = dir_dy(r_d);
    assign w_on_board  = (r_x >= 0) && (r_x < BOARD_SIZE) && (r_y >= 0) && (r_y < BOARD_SIZE);
    assign w_walk_last = (r_j == 4'd10);
    assign w_sweep_last = (r_k == IDX_W'(CELLS - 1));

    // code update for the row being walked
    assign w_delta = (r_col == 2'd2) ? (PW3[r_j] << 1) : PW3[r_j];
    assign w_oc    = w_b_rdata.code[r_d];
    assign w_nc    = r_sub ? (w_oc - w_delta) : (w_oc + w_delta);

    // memory address and write selection
    always_comb begin
        w_b_we      = 1'b0;
        w_b_waddr   = r_k[AW-1:0];
        w_b_wdata   = r_row;
        w_b_raddr   = r_loc;
        w_w_raddr_a = w_wall[0];
        w_w_raddr_b = w_wall[1];
        case (r_state)
            S_INIT: begin
                w_b_we           = 1'b1;
                w_b_wdata.color  = 2'd0;
                w_b_wdata.code   = w_wall;
                w_b_wdata.policy = '0;
            end
            S_CELL_CHK: begin
                w_b_waddr       = r_loc;
                w_b_wdata       = w_b_rdata;
                w_b_wdata.color = r_sub ? 2'd0 : r_col;
                w_b_we          = r_sub ? (w_b_rdata.color != 2'd0)
                                        : (w_b_rdata.color == 2'd0);
            end
            S_WALK_RD: begin
                w_b_raddr = r_k[AW-1:0];
            end
            S_WALK_MOD: begin
                w_w_raddr_a = w_oc;
                w_w_raddr_b = w_nc;
            end
            S_WALK_WR: begin
                w_b_we                = 1'b1;
                w_b_wdata.code[r_d]   = r_nc;
                w_b_wdata.policy      = r_row.policy - POL_W'(wx(w_w_rdata_a[0]))
                                        + POL_W'(wx(w_w_rdata_b[0]));
            end
            S_CLR_B: begin
                w_w_raddr_a = w_wall[2];
                w_w_raddr_b = w_wall[3];
            end
            S_CLR_C: begin
                w_b_we           = 1'b1;
                w_b_wdata.color  = 2'd0;
                w_b_wdata.code   = w_wall;
                w_b_wdata.policy = r_pacc + POL_W'(wx(w_w_rdata_a[0]))
                                   + POL_W'(wx(w_w_rdata_b[0]));
            end
            default: begin
            end
        endcase
    end

    // sequencer and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_x         <= '0;
            r_y         <= '0;
            r_k         <= '0;
            r_win       <= '0;
            r_loss      <= '0;
            r_draw      <= '0;
            r_out_valid <= 1'b0;
            r_d         <= '0;
            r_j         <= '0;
        end else begin
            // result beat taken; the result state refills it itself
            if (!i_out_stall && (r_state != S_RES)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    if (w_sweep_last) begin
                        r_state <= S_IDLE;
                    end
                    r_k <= r_k + 1'b1;
                    if (r_x == COORD_W'(BOARD_SIZE - 1)) begin
                        r_x <= '0;
                        r_y <= r_y + 1'b1;
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_cell_ok <= (16'(i_in_beat.cell_req) < 16'(CELLS));
                        r_loc     <= AW'(i_in_beat.cell_req);
                        r_rem     <= AW'(i_in_beat.cell_req);
                        r_y0      <= '0;
                        r_col     <= i_in_beat.stone;
                        r_state   <= S_RES_RD;
                        case (i_in_beat.kind)
                            KIND_PLACE: begin
                                r_sub <= 1'b0;
                                if ((16'(i_in_beat.cell_req) < 16'(CELLS)) &&
                                    (i_in_beat.stone == 2'd1 || i_in_beat.stone == 2'd2)) begin
                                    r_state <= S_DIVY;
                                end
                            end
                            KIND_REMOVE: begin
                                r_sub <= 1'b1;
                                if (16'(i_in_beat.cell_req) < 16'(CELLS)) begin
                                    r_state <= S_DIVY;
                                end
                            end
                            KIND_CLEAR: begin
                                r_win   <= '0;
                                r_loss  <= '0;
                                r_draw  <= '0;
                                r_x     <= '0;
                                r_y     <= '0;
                                r_k     <= '0;
                                r_state <= S_CLR_A;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DIVY: begin
                    // split the cell index by repeated subtraction
                    if (r_rem >= AW'(BOARD_SIZE)) begin
                        r_rem <= r_rem - AW'(BOARD_SIZE);
                        r_y0  <= r_y0 + 1'b1;
                    end else begin
                        r_x0    <= COORD_W'(r_rem);
                        r_state <= S_CELL_RD;
                    end
                end
                S_CELL_RD: begin
                    r_state <= S_CELL_CHK;
                end
                S_CELL_CHK: begin
                    if (r_sub) begin
                        r_col <= w_b_rdata.color;
                    end
                    r_d <= '0;
                    r_j <= '0;
                    r_x <= w_sx;
                    r_y <= w_sy;
                    r_k <= w_sk;
                    r_state <= w_b_we ? S_WALK_RD : S_RES_RD;
                end
                S_WALK_RD, S_WALK_WR: begin
                    if (r_state == S_WALK_RD && w_on_board) begin
                        r_state <= S_WALK_MOD;
                    end else begin
                        if (r_state == S_WALK_WR) begin
                            r_win  <= r_win - wx(w_w_rdata_a[1]) + wx(w_w_rdata_b[1]);
                            r_loss <= r_loss - wx(w_w_rdata_a[2]) + wx(w_w_rdata_b[2]);
                            r_draw <= r_draw - wx(w_w_rdata_a[3]) + wx(w_w_rdata_b[3]);
                        end
                        r_state <= S_WALK_RD;
                        if (w_walk_last) begin
                            if (r_d == 2'd3) begin
                                r_state <= S_RES_RD;
                            end
                            r_d <= r_d + 1'b1;
                            r_j <= '0;
                            r_x <= w_sx;
                            r_y <= w_sy;
                            r_k <= w_sk;
                        end else begin
                            r_j <= r_j + 1'b1;
                            r_x <= r_x - COORD_W'(w_dx);
                            r_y <= r_y - COORD_W'(w_dy);
                            r_k <= r_k - w_off;
                        end
                    end
                end
                S_WALK_MOD: begin
                    r_row   <= w_b_rdata;
                    r_nc    <= w_nc;
                    r_state <= S_WALK_WR;
                end
                S_CLR_A: begin
                    r_state <= S_CLR_B;
                end
                S_CLR_B: begin
                    r_pacc <= POL_W'(wx(w_w_rdata_a[0])) + POL_W'(wx(w_w_rdata_b[0]));
                    r_win  <= r_win + wx(w_w_rdata_a[1]) + wx(w_w_rdata_b[1]);
                    r_loss <= r_loss + wx(w_w_rdata_a[2]) + wx(w_w_rdata_b[2]);
                    r_draw <= r_draw + wx(w_w_rdata_a[3]) + wx(w_w_rdata_b[3]);
                    r_state <= S_CLR_C;
                end
                S_CLR_C: begin
                    r_win  <= r_win + wx(w_w_rdata_a[1]) + wx(w_w_rdata_b[1]);
                    r_loss <= r_loss + wx(w_w_rdata_a[2]) + wx(w_w_rdata_b[2]);
                    r_draw <= r_draw + wx(w_w_rdata_a[3]) + wx(w_w_rdata_b[3]);
                    r_state <= w_sweep_last ? S_RES_RD : S_CLR_A;
                    r_k <= r_k + 1'b1;
                    if (r_x == COORD_W'(BOARD_SIZE - 1)) begin
                        r_x <= '0;
                        r_y <= r_y + 1'b1;
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
                S_RES_RD: begin
                    r_state <= S_RES;
                end
                S_RES: begin
                    // hold until the previous beat has gone
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_beat.policy_value <= r_cell_ok ? w_b_rdata.policy : '0;
                        r_out_beat.win_total    <= r_win;
                        r_out_beat.loss_total   <= r_loss;
                        r_out_beat.draw_total   <= r_draw;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // reset always starts the wall init sweep
    a_reset_init: assert property (@(posedge i_clk) !i_rst_n |=> r_state == S_INIT)
        else $error("init sweep not started after reset");
    // board rows are written only by sweep, colour update or code update
    a_board_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_b_we |-> (r_state == S_INIT || r_state == S_CELL_CHK ||
                    r_state == S_WALK_WR || r_state == S_CLR_C))
        else $error("board write outside an update state");
    // walk slot counter stays within the eleven slots of a line
    a_walk_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j <= 4'd10)
        else $error("walk slot counter overran");
    // a touched row is always on the board
    a_walk_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK_MOD |-> $past(w_on_board))
        else $error("walk read an off-board row");
`endif

endmodule
